// File: rtl/core/gcis_pkg.sv
// Package: shared types, constants and helpers of the glyph cluster index search unit.
`default_nettype none

package gcis_pkg;

  localparam int STORE_DEPTH_DEF  = 256;
  localparam int CLUSTER_BITS_DEF = 16;

  localparam int ADDR_W   = 8;
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 16;
  localparam int GIDX_W   = 9;
  localparam int NEXT_W   = 17;
  localparam int IDX_W    = 11;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 16;

  localparam logic signed [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic signed [IDX_W-1:0] IDX_NONE = -IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_RUN_START   = 2'd0,
    REG_RUN_LENGTH  = 2'd1,
    REG_RTL         = 2'd2,
    REG_RUN_OFFSET  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_RESOLVE,
    ST_NEXT,
    ST_NEXT_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              en;
    logic [GIDX_W-1:0] idx;
  } rd_req_t;

  // 8-bit value modulo depth, restoring compare-subtract over eight steps
  function automatic logic [ADDR_W-1:0] wrap8(logic [ADDR_W-1:0] v, int unsigned depth);
    logic [31:0] r;
    r = 32'(v);
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if (r >= (depth << k)) begin
        r = r - (depth << k);
      end
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcis_ifs.sv
// Interfaces: request, response and configuration channels.
`default_nettype none

interface gcis_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      cmd;
  logic [gcis_pkg::ADDR_W-1:0]     entry_addr;
  logic [gcis_pkg::VALUE_W-1:0]    cluster_value;
  logic [gcis_pkg::POS_W-1:0]      position;

  modport source (output valid, cmd, entry_addr, cluster_value, position, input ready);
  modport sink   (input valid, cmd, entry_addr, cluster_value, position, output ready);
endinterface

interface gcis_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [gcis_pkg::GIDX_W-1:0]       glyph_index;
  logic signed [gcis_pkg::NEXT_W-1:0] next_position;

  modport source (output valid, found, glyph_index, next_position, input ready);
  modport sink   (input valid, found, glyph_index, next_position, output ready);
endinterface

interface gcis_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gcis_pkg::CFG_A_W-1:0]   addr;
  logic [gcis_pkg::CFG_D_W-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gcis_store.sv
// Cluster store: one write port, one registered read port with run-relative wrapped addressing.
`default_nettype none

module gcis_store #(
  parameter int STORE_DEPTH  = gcis_pkg::STORE_DEPTH_DEF,
  parameter int CLUSTER_BITS = gcis_pkg::CLUSTER_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [gcis_pkg::ADDR_W-1:0]          wr_addr,
  input  wire logic [CLUSTER_BITS-1:0]              wr_data,
  input  wire logic [$clog2(STORE_DEPTH)-1:0]       base,
  input  wire gcis_pkg::rd_req_t                    rd,
  output      logic [CLUSTER_BITS-1:0]              rd_data
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int SUM_W = ((AW > gcis_pkg::GIDX_W) ? AW : gcis_pkg::GIDX_W) + 1;

  logic [CLUSTER_BITS-1:0] mem [STORE_DEPTH];
  logic [AW-1:0]           wa;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        sum_wrap;
  logic [AW-1:0]           ra;

  assign wa = AW'(gcis_pkg::wrap8(wr_addr, STORE_DEPTH));

  // base < depth and idx < depth, so one subtract wraps the sum
  assign sum      = SUM_W'(base) + SUM_W'(rd.idx);
  assign sum_wrap = (sum >= SUM_W'(STORE_DEPTH)) ? sum - SUM_W'(STORE_DEPTH) : sum;
  assign ra       = sum_wrap[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[ra];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/glyph_cluster_index_search_unit.sv
// Top level: config registers, binary-search sequencer over the cluster store, response register.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  req     | in  | valid/ready | cmd, entry_addr, cluster_value, position
//  rsp     | out | valid/ready | found, glyph_index, next_position
//  cfg     | in  | valid/ready | addr (register index), data; always ready
//
//  Write and unused commands go straight from idle to finish. Find probes the store
//  at most ceil(log2(run length)) + 1 times, walks to the cluster edge, and resolves
//  the index on a hit; next also reads the neighbor if it has one. Each probe or walk step is one
//  store read plus a compare. One request at a time; req.ready is high only when idle.
//  A waiting response sits in the output register; a stalled rsp holds the
//  sequencer at its last state. Reset (rst, synchronous) clears control and config.
`default_nettype none

module glyph_cluster_index_search_unit #(
  parameter int STORE_DEPTH  = gcis_pkg::STORE_DEPTH_DEF,
  parameter int CLUSTER_BITS = gcis_pkg::CLUSTER_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  gcis_req_if.sink    req,
  gcis_rsp_if.source  rsp,
  gcis_cfg_if.sink    cfg
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int CMP_W   = (CLUSTER_BITS > gcis_pkg::NEXT_W) ? CLUSTER_BITS : gcis_pkg::NEXT_W;
  localparam int LEN_CAP = (STORE_DEPTH < 511) ? STORE_DEPTH : 511;
  localparam int IW      = gcis_pkg::IDX_W;

  // config
  logic [AW-1:0]                  run_base;
  logic [gcis_pkg::GIDX_W-1:0]    run_length;
  logic                           rtl;
  logic [gcis_pkg::POS_W-1:0]     run_offset;

  // sequencer
  gcis_pkg::state_t               state, state_next;
  logic [1:0]                     cmd_r;
  logic [gcis_pkg::POS_W-1:0]     pos_r;
  logic [gcis_pkg::NEXT_W-1:0]    cutoff;
  logic signed [IW-1:0]           lo, lo_next;
  logic signed [IW-1:0]           hi, hi_next;
  logic signed [IW-1:0]           mid, mid_next;
  logic signed [IW-1:0]           idx, idx_next;
  logic                           found_r, found_next;
  logic [gcis_pkg::GIDX_W-1:0]    gidx_r, gidx_next;
  logic [gcis_pkg::NEXT_W-1:0]    nextp_r, nextp_next;

  // response register
  logic                           rsp_valid;
  logic                           rsp_found;
  logic [gcis_pkg::GIDX_W-1:0]    rsp_gidx;
  logic [gcis_pkg::NEXT_W-1:0]    rsp_nextp;

  // store access
  gcis_pkg::rd_req_t              rd_req;
  logic [CLUSTER_BITS-1:0]        rd_data;
  logic                           wr_en;

  // shared compare / step unit
  logic [gcis_pkg::GIDX_W-1:0]    eff_len;
  logic signed [IW-1:0]           len_s;
  logic [CMP_W-1:0]               cut_w, val_w;
  logic                           c_lt, c_gt, c_eq;
  logic                           go_low, go_high;
  logic signed [IW-1:0]           lo_step, hi_step;
  logic                           probe_miss;
  logic signed [IW-1:0]           walk_pos;
  logic                           walk_in;
  logic signed [IW-1:0]           nb_idx;
  logic                           have_nb;
  logic                           req_acc;
  logic                           out_load;

  assign req.ready = (state == gcis_pkg::ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_load  = (state == gcis_pkg::ST_FINISH) && (!rsp_valid || rsp.ready);

  assign eff_len = (run_length > gcis_pkg::GIDX_W'(LEN_CAP)) ?
                   gcis_pkg::GIDX_W'(LEN_CAP) : run_length;
  assign len_s   = signed'(IW'(eff_len));

  assign cut_w   = CMP_W'(cutoff);
  assign val_w   = CMP_W'(rd_data);
  assign c_lt    = cut_w < val_w;
  assign c_gt    = cut_w > val_w;
  assign c_eq    = cut_w == val_w;
  assign go_low  = rtl ? c_gt : c_lt;
  assign go_high = rtl ? c_lt : c_gt;
  assign lo_step = go_high ? mid + gcis_pkg::IDX_ONE : lo;
  assign hi_step = go_low  ? mid - gcis_pkg::IDX_ONE : hi;
  assign probe_miss = lo_step > hi_step;

  assign walk_pos = rtl ? mid + gcis_pkg::IDX_ONE : mid - gcis_pkg::IDX_ONE;
  assign walk_in  = rtl ? (walk_pos < len_s) : !walk_pos[IW-1];

  assign nb_idx  = rtl ? idx - gcis_pkg::IDX_ONE : idx + gcis_pkg::IDX_ONE;
  assign have_nb = rtl ? (!idx[IW-1] && idx != gcis_pkg::IDX_W'(0))
                       : (idx < len_s - gcis_pkg::IDX_ONE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_base    <= '0;
      run_length  <= '0;
      rtl         <= 1'b0;
      run_offset  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.addr)
        gcis_pkg::REG_RUN_START:   run_base <=
          AW'(gcis_pkg::wrap8(cfg.data[gcis_pkg::ADDR_W-1:0], STORE_DEPTH));
        gcis_pkg::REG_RUN_LENGTH:  run_length  <= cfg.data[gcis_pkg::GIDX_W-1:0];
        gcis_pkg::REG_RTL:         rtl         <= cfg.data[0];
        gcis_pkg::REG_RUN_OFFSET:  run_offset  <= cfg.data[gcis_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gcis_pkg::ST_IDLE: begin
        if (req_acc) begin
          if (req.cmd == gcis_pkg::CMD_FIND || req.cmd == gcis_pkg::CMD_NEXT) begin
            state_next = gcis_pkg::ST_START;
          end else begin
            state_next = gcis_pkg::ST_FINISH;
          end
        end
      end
      gcis_pkg::ST_START: begin
        state_next = (eff_len == '0) ? gcis_pkg::ST_NEXT : gcis_pkg::ST_PROBE_RD;
      end
      gcis_pkg::ST_PROBE_RD: state_next = gcis_pkg::ST_PROBE_CMP;
      gcis_pkg::ST_PROBE_CMP: begin
        if (c_eq) begin
          state_next = walk_in ? gcis_pkg::ST_WALK_RD : gcis_pkg::ST_RESOLVE;
        end else if (probe_miss) begin
          state_next = gcis_pkg::ST_NEXT;
        end else begin
          state_next = gcis_pkg::ST_PROBE_RD;
        end
      end
      gcis_pkg::ST_WALK_RD: state_next = gcis_pkg::ST_WALK_CMP;
      gcis_pkg::ST_WALK_CMP: begin
        if (c_eq && walk_in) begin
          state_next = gcis_pkg::ST_WALK_RD;
        end else begin
          state_next = gcis_pkg::ST_RESOLVE;
        end
      end
      gcis_pkg::ST_RESOLVE: state_next = gcis_pkg::ST_NEXT;
      gcis_pkg::ST_NEXT: begin
        if (cmd_r == gcis_pkg::CMD_NEXT && have_nb) begin
          state_next = gcis_pkg::ST_NEXT_CMP;
        end else begin
          state_next = gcis_pkg::ST_FINISH;
        end
      end
      gcis_pkg::ST_NEXT_CMP: state_next = gcis_pkg::ST_FINISH;
      gcis_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = gcis_pkg::ST_IDLE;
        end
      end
      default: state_next = gcis_pkg::ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    idx_next   = idx;
    found_next = found_r;
    gidx_next  = gidx_r;
    nextp_next = nextp_r;
    rd_req     = '0;
    wr_en      = 1'b0;
    case (state)
      gcis_pkg::ST_IDLE: begin
        found_next = 1'b0;
        gidx_next  = '0;
        nextp_next = '0;
        wr_en      = req_acc && (req.cmd == gcis_pkg::CMD_WRITE);
      end
      gcis_pkg::ST_START: begin
        lo_next  = '0;
        hi_next  = len_s - gcis_pkg::IDX_ONE;
        idx_next = gcis_pkg::IDX_NONE;
        if (cutoff < gcis_pkg::NEXT_W'(eff_len)) begin
          mid_next = signed'(IW'(cutoff));
        end else begin
          mid_next = (len_s - gcis_pkg::IDX_ONE) >>> 1;
        end
      end
      gcis_pkg::ST_PROBE_RD, gcis_pkg::ST_WALK_RD: begin
        rd_req.en  = 1'b1;
        rd_req.idx = mid[gcis_pkg::GIDX_W-1:0];
      end
      gcis_pkg::ST_PROBE_CMP: begin
        if (c_eq) begin
          mid_next = walk_pos;
        end else begin
          lo_next  = lo_step;
          hi_next  = hi_step;
          mid_next = (lo_step + hi_step) >>> 1;
        end
      end
      gcis_pkg::ST_WALK_CMP: begin
        if (c_eq) begin
          mid_next = walk_pos;
        end
      end
      gcis_pkg::ST_RESOLVE: begin
        idx_next   = rtl ? len_s - mid : mid + gcis_pkg::IDX_ONE;
        found_next = 1'b1;
        gidx_next  = rtl ? gcis_pkg::GIDX_W'(len_s - mid)
                         : gcis_pkg::GIDX_W'(mid + gcis_pkg::IDX_ONE);
      end
      gcis_pkg::ST_NEXT: begin
        if (cmd_r == gcis_pkg::CMD_NEXT) begin
          if (have_nb) begin
            rd_req.en  = 1'b1;
            rd_req.idx = nb_idx[gcis_pkg::GIDX_W-1:0];
          end else begin
            nextp_next = gcis_pkg::NEXT_W'(pos_r);
          end
        end
      end
      gcis_pkg::ST_NEXT_CMP: begin
        nextp_next = gcis_pkg::NEXT_W'(rd_data) - gcis_pkg::NEXT_W'(run_offset);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    idx     <= idx_next;
    found_r <= found_next;
    gidx_r  <= gidx_next;
    nextp_r <= nextp_next;
    if (req_acc) begin
      cmd_r  <= req.cmd;
      pos_r  <= req.position;
      cutoff <= gcis_pkg::NEXT_W'(req.position) + gcis_pkg::NEXT_W'(run_offset);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_found <= found_r;
      rsp_gidx  <= gidx_r;
      rsp_nextp <= nextp_r;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.found         = rsp_found;
  assign rsp.glyph_index   = rsp_gidx;
  assign rsp.next_position = signed'(rsp_nextp);

  gcis_store #(
    .STORE_DEPTH  (STORE_DEPTH),
    .CLUSTER_BITS (CLUSTER_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (req.entry_addr),
    .wr_data (CLUSTER_BITS'(req.cluster_value)),
    .base    (run_base),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/gcis_checker.sv
// Port-level checker for the glyph cluster index search unit, bound to the top level.
`default_nettype none

module gcis_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_found,
  input wire logic [8:0]  rsp_glyph_index,
  input wire logic [16:0] rsp_next_position
);

  logic [1:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_acc && !rsp_acc) begin
      pending <= pending + 2'd1;
    end else if (rsp_acc && !req_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_found, rsp_glyph_index, rsp_next_position}))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req_ready)
    else $error("request taken while previous one in work");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_glyph_index == 9'd0)
    else $error("miss with nonzero glyph index");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests outstanding");

  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without a request");

endmodule

bind glyph_cluster_index_search_unit gcis_checker u_gcis_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_found         (rsp.found),
  .rsp_glyph_index   (rsp.glyph_index),
  .rsp_next_position (rsp.next_position)
);

`default_nettype wire

// File: bench/tb.sv
// Testbench: glyph cluster index search unit, predicted request by request and checked.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [15:0] value;
    logic [15:0] pos;
  } glyph_req_t;

  typedef struct packed {
    logic        found;
    logic [8:0]  glyph_index;
    logic [16:0] next_position;
  } cluster_answer_t;

  logic clk;
  logic rst;

  gcis_req_if req_ch ();
  gcis_rsp_if rsp_ch ();
  gcis_cfg_if cfg_ch ();

  glyph_cluster_index_search_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // model of the block
  logic [15:0] cluster_mem [256];
  logic [7:0]  m_start;
  logic [8:0]  m_len;
  logic        m_rtl;
  logic [15:0] m_offset;

  glyph_req_t      req_pending [$];
  glyph_req_t      req_cur;
  cluster_answer_t answers_due [$];

  int  items_sent;
  int  err_count;
  int  send_gap;
  int  take_stall;
  int  hold_left;
  int  hold_asked;
  int  hold_done;
  int  cycles;
  bit  send_gaps_on;
  bit  take_gaps_on;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = gcis_pkg::CMD_WRITE;
    req_ch.entry_addr = '0;
    req_ch.cluster_value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = gcis_pkg::REG_RUN_START;
    cfg_ch.data = '0;
    forever #5 clk = ~clk;
  end

  function automatic int run_span();
    return (m_len > 9'd256) ? 256 : int'(m_len);
  endfunction

  function automatic int cluster_of(input int idx);
    logic [7:0] a;
    a = 8'(int'(m_start) + idx);
    return int'(cluster_mem[a]);
  endfunction

  // glyph index of the cluster at cutoff, -1 on a miss
  function automatic int locate_glyph(input int cutoff);
    int len, lo, hi, mid, v;
    bit go_low, go_high;
    len = run_span();
    if (len <= 0) return -1;
    lo = 0;
    hi = len - 1;
    mid = (cutoff >= lo && cutoff <= hi) ? cutoff : (lo + hi) / 2;
    forever begin
      v = cluster_of(mid);
      go_low = m_rtl ? (cutoff > v) : (cutoff < v);
      go_high = m_rtl ? (cutoff < v) : (cutoff > v);
      if (go_low) hi = mid - 1;
      else if (go_high) lo = mid + 1;
      else break;
      if (lo > hi) break;
      mid = (lo + hi) / 2;
    end
    if (lo > hi) return -1;
    if (m_rtl) begin
      while (mid < len && cluster_of(mid) == cutoff) mid++;
      return len - mid;
    end
    while (mid >= 0 && cluster_of(mid) == cutoff) mid--;
    return mid + 1;
  endfunction

  function automatic cluster_answer_t predict_answer(input glyph_req_t r);
    cluster_answer_t a;
    int idx, len, nxt;
    a = '0;
    len = run_span();
    case (r.cmd)
      gcis_pkg::CMD_WRITE: cluster_mem[r.addr] = r.value;
      gcis_pkg::CMD_FIND, gcis_pkg::CMD_NEXT: begin
        idx = locate_glyph(int'(r.pos) + int'(m_offset));
        if (idx >= 0) begin
          a.found = 1'b1;
          a.glyph_index = 9'(idx);
        end
        if (r.cmd == gcis_pkg::CMD_NEXT) begin
          nxt = int'(r.pos);
          if (m_rtl) begin
            if (idx > 0) nxt = cluster_of(idx - 1) - int'(m_offset);
          end else if (idx < len - 1) begin
            nxt = cluster_of(idx + 1) - int'(m_offset);
          end
          a.next_position = 17'(nxt);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 100) $display("mismatch: %s", msg);
  endtask

  task automatic check_answer();
    cluster_answer_t want;
    if (answers_due.size() == 0) begin
      report("response with no request outstanding");
    end else begin
      want = answers_due.pop_front();
      if (rsp_ch.found !== want.found)
        report($sformatf("found got %b want %b", rsp_ch.found, want.found));
      if (rsp_ch.glyph_index !== want.glyph_index)
        report($sformatf("glyph_index got %0d want %0d",
                         rsp_ch.glyph_index, want.glyph_index));
      if (rsp_ch.next_position !== want.next_position)
        report($sformatf("next_position got %0d want %0d",
                         rsp_ch.next_position, $signed(want.next_position)));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) answers_due.push_back(predict_answer(req_cur));
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (req_pending.size() > 0) begin
        req_cur = req_pending.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= req_cur.cmd;
        req_ch.entry_addr <= req_cur.addr;
        req_ch.cluster_value <= req_cur.value;
        req_ch.position <= req_cur.pos;
        send_gap <= send_gaps_on ? int'($urandom_range(0, 6)) : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_answer();
        take_stall = take_gaps_on ? int'($urandom_range(0, 6)) : 0;
      end else if (take_stall > 0) begin
        take_stall--;
      end
      rsp_ch.ready <= (take_stall == 0) && (hold_left == 0);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asked;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input gcis_pkg::cfg_reg_t r, input logic [15:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= r;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    case (r)
      gcis_pkg::REG_RUN_START:   m_start = v[7:0];
      gcis_pkg::REG_RUN_LENGTH:  m_len = v[8:0];
      gcis_pkg::REG_RTL:         m_rtl = v[0];
      gcis_pkg::REG_RUN_OFFSET:  m_offset = v;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_run(input int start, input int len, input bit rtl, input int offset);
    write_reg(gcis_pkg::REG_RUN_START, 16'(start));
    write_reg(gcis_pkg::REG_RUN_LENGTH, 16'(len));
    write_reg(gcis_pkg::REG_RTL, 16'(rtl));
    write_reg(gcis_pkg::REG_RUN_OFFSET, 16'(offset));
  endtask

  task automatic push_req(input logic [1:0] c, input logic [7:0] a, input logic [15:0] v,
                          input logic [15:0] p);
    glyph_req_t it;
    it.cmd = c;
    it.addr = a;
    it.value = v;
    it.pos = p;
    req_pending.push_back(it);
    items_sent++;
  endtask

  task automatic push_write(input logic [7:0] a, input logic [15:0] v);
    push_req(gcis_pkg::CMD_WRITE, a, v, 16'($urandom));
  endtask

  task automatic push_query(input logic [1:0] c, input logic [15:0] p);
    push_req(c, 8'($urandom), 16'($urandom), p);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_pending.size() != 0 || req_ch.valid || answers_due.size() != 0);
  endtask

  task automatic run_phase(input int start, input int len_reg, input bit rtl,
                           input int n_q, input bit hold);
    int eff, base, shape, v, g, offset, roll;
    int vals[$];
    logic [1:0] c;
    logic [15:0] p;
    eff = (len_reg > 256) ? 256 : len_reg;
    shape = $urandom_range(0, 3);
    case (shape)
      0: base = $urandom_range(0, 2);
      1: base = $urandom_range(0, 65535 - 4 * eff);
      2: base = 0;
      default: base = $urandom_range(0, 65000);
    endcase
    v = base;
    for (int k = 0; k < eff; k++) begin
      if (shape == 3) v = base + $urandom_range(0, 40);
      else if (k > 0 && $urandom_range(0, 2) != 0) v += $urandom_range(1, shape == 0 ? 1 : 4);
      vals.push_back(v);
    end
    // push the top cluster to the maximum value
    if (shape == 2 && eff > 0) begin
      g = 65535 - vals[eff - 1];
      foreach (vals[k]) vals[k] += g;
      base += g;
    end
    if (rtl) vals.reverse();
    roll = $urandom_range(0, 3);
    if (shape == 0) offset = 0;
    else if (roll == 0) offset = base;
    else if (roll == 1) offset = $urandom_range(0, 65535);
    else offset = $urandom_range(0, base);
    set_run(start, len_reg, rtl, offset);
    foreach (vals[k]) push_write(8'(start + k), 16'(vals[k]));
    if ($urandom_range(0, 2) == 0) wait_drained();
    if (hold) hold_asked++;
    for (int q = 0; q < n_q; q++) begin
      roll = $urandom_range(0, 19);
      c = $urandom_range(0, 1) ? gcis_pkg::CMD_FIND : gcis_pkg::CMD_NEXT;
      g = (eff > 0) ? vals[$urandom_range(0, eff - 1)] - offset : int'($urandom_range(0, 65535));
      if (roll < 14) p = 16'(g);
      else if (roll < 16) p = 16'(g + ($urandom_range(0, 1) ? 1 : -1));
      else p = 16'($urandom);
      if (roll == 18) push_write(8'($urandom), 16'($urandom));
      else if (roll == 19) push_req(CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
      else push_query(c, p);
    end
  endtask

  initial begin
    int p, start, len, r;
    bit rtl;
    items_sent = 0;
    err_count = 0;
    hold_asked = 0;
    cycles = 0;
    send_gaps_on = 1'b1;
    take_gaps_on = 1'b1;
    m_start = '0;
    m_len = '0;
    m_rtl = 1'b0;
    m_offset = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ascending run wrapping past the store end, with repeated clusters
    set_run(254, 6, 1'b0, 0);
    push_write(8'd254, 16'd2);
    push_write(8'd255, 16'd2);
    push_write(8'd0, 16'd4);
    push_write(8'd1, 16'd4);
    push_write(8'd2, 16'd4);
    push_write(8'd3, 16'hFFFF);
    push_query(gcis_pkg::CMD_FIND, 16'd2);
    push_query(gcis_pkg::CMD_FIND, 16'd4);
    push_query(gcis_pkg::CMD_FIND, 16'hFFFF);
    push_query(gcis_pkg::CMD_FIND, 16'd0);
    push_query(gcis_pkg::CMD_FIND, 16'd3);
    push_query(gcis_pkg::CMD_FIND, 16'hFFFE);
    push_query(gcis_pkg::CMD_NEXT, 16'd2);
    push_query(gcis_pkg::CMD_NEXT, 16'd4);
    push_query(gcis_pkg::CMD_NEXT, 16'hFFFF);
    push_query(gcis_pkg::CMD_NEXT, 16'd3);
    push_req(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // right-to-left run of one cluster at the top offset
    set_run(255, 4, 1'b1, 16'hFFFF);
    push_write(8'd255, 16'hFFFF);
    push_write(8'd0, 16'hFFFF);
    push_write(8'd1, 16'hFFFF);
    push_write(8'd2, 16'hFFFF);
    push_query(gcis_pkg::CMD_FIND, 16'd0);
    push_query(gcis_pkg::CMD_NEXT, 16'd0);
    push_query(gcis_pkg::CMD_FIND, 16'd1);
    push_query(gcis_pkg::CMD_NEXT, 16'hFFFF);
    wait_drained();

    // empty run
    set_run(0, 0, 1'b0, 0);
    push_query(gcis_pkg::CMD_FIND, 16'd0);
    push_query(gcis_pkg::CMD_NEXT, 16'd7);
    wait_drained();

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      start = (r == 0) ? 0 : (r == 1) ? 255 : int'($urandom_range(0, 255));
      rtl = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 19);
      if (p == 2) len = 256;
      else if (p == 5) begin
        len = 511;
        rtl = 1'b1;
      end else if (r == 0) len = 0;
      else if (r < 3) len = $urandom_range(17, 64);
      else len = $urandom_range(1, 16);
      send_gaps_on = ($urandom_range(0, 3) != 0);
      take_gaps_on = ($urandom_range(0, 3) != 0);
      run_phase(start, len, rtl, $urandom_range(10, 30), p == 1 || p % 9 == 4);
      wait_drained();
      p++;
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gcis_pkg.sv
rtl/core/gcis_ifs.sv
rtl/core/gcis_store.sv
rtl/core/glyph_cluster_index_search_unit.sv
rtl/core/gcis_checker.sv
bench/tb.sv
